/* rtl/mbw_pkg.sv */
`timescale 1ns / 1ps
// Package for the bottleneck spanning-tree block.
// Holds the fixed port field widths. No dependencies.
package mbw_pkg;

    localparam int NODE_FW  = 10;   // endpoint field width
    localparam int WGT_FW   = 20;   // weight field width on the ports
    localparam int CFG_FW   = 11;   // node count register width
    localparam int S_DATA_W = 40;   // input tdata: two endpoints and weight
    localparam int M_DATA_W = 24;   // output tdata: 22 bits of fields, byte padded

endpackage

/* rtl/mbw_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mst_bottleneck_weight.sv */
`timescale 1ns / 1ps
// Minimum bottleneck spanning tree over a loaded edge set.
// Depends on mbw_pkg and mbw_ram.
//
// Use: edges arrive on the s_ channel, one item per cycle while loading.
// s_tuser is has_edge, s_tlast ends the edge set. On the last item the block
// drops s_tready and computes; one result item then leaves on the m_ channel:
// connected, bottleneck weight (0 when not connected) and whether edges beyond
// the MAX_EDGES store were discarded. Configure node_count through cfg_we /
// cfg_wdata while idle.
// Compute: after the last item the block finds the smallest weight threshold
// at which the stored edges connect all nodes: one full pass plus one pass
// per weight bit (WEIGHT_BITS + 1 passes), each pass stopping once the tree
// is complete. A pass resets the parent table for node_count nodes, reads
// each stored edge, searches the roots of both endpoints for an edge in range
// and under the threshold, links them when they differ, and then closes. A
// start step begins the compute and a final step hands the result over; with
// one node or no edges the start step skips the passes.
// Reset (aresetn low, synchronous) empties the edge set, drops m_tvalid and
// sets node_count to 1. A stalled receiver holds the result in the output
// register; the block returns to loading once the next result can enter it.
module mst_bottleneck_weight #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: node_count
    input  logic                         cfg_we,
    input  logic [mbw_pkg::CFG_FW-1:0]   cfg_wdata,
    // Input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mbw_pkg::S_DATA_W-1:0] s_tdata,  // end_node_a, end_node_b, edge_weight
    input  logic                         s_tuser,  // has_edge
    input  logic                         s_tlast,  // last_edge
    // Result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbw_pkg::M_DATA_W-1:0] m_tdata   // connected, bottleneck_weight,
                                                   // edges_dropped, zero pad
);

    import mbw_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int WB  = WEIGHT_BITS;
    localparam int BIW = (WB > 1) ? $clog2(WB) : 1;
    localparam int EW  = 2 * NODE_FW + WB;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_EREAD = 4'd3;
    localparam logic [3:0] S_ECHK  = 4'd4;
    localparam logic [3:0] S_FA    = 4'd5;
    localparam logic [3:0] S_FAW   = 4'd6;
    localparam logic [3:0] S_FB    = 4'd7;
    localparam logic [3:0] S_FBW   = 4'd8;
    localparam logic [3:0] S_PEND  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CFG_FW-1:0] ncfg_reg, ncfg_next;
    logic [NCW-1:0]    nc_reg, nc_next;
    logic [ECW-1:0]    cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic              drop_reg, drop_next;
    logic [WB-1:0]     thr_reg, thr_next;
    logic [WB-1:0]     ans_reg, ans_next;
    logic [BIW-1:0]    bit_reg, bit_next;
    logic              first_reg, first_next;
    logic              pconn_reg, pconn_next;
    logic [NCW-1:0]    ii_reg, ii_next;
    logic [ECW-1:0]    ei_reg, ei_next;
    logic [NCW-1:0]    joins_reg, joins_next;
    logic [NAW-1:0]    x_reg, x_next;
    logic [NAW-1:0]    ra_reg, ra_next;
    logic [NAW-1:0]    eb_reg, eb_next;
    logic              res_conn_reg, res_conn_next;
    logic [WB-1:0]     res_w_reg, res_w_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_conn_reg, m_conn_next;
    logic [WGT_FW-1:0] m_bw_reg, m_bw_next;
    logic              m_drop_reg, m_drop_next;

    logic              s_fire;
    logic              e_we;
    logic [EW-1:0]     e_wdata, e_rdata;
    logic [WB-1:0]     w_in;
    logic              p_we;
    logic [NAW-1:0]    p_waddr, p_wdata, p_raddr, p_rdata;
    logic [NODE_FW-1:0] rd_a, rd_b;
    logic [WB-1:0]     rd_w;
    logic [WB-1:0]     ans_upd;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign w_in     = WB'(32'(s_tdata[2*NODE_FW +: WGT_FW]));
    assign e_we     = s_fire && s_tuser && (32'(cnt_reg) < MAX_EDGES);
    assign e_wdata  = {w_in, s_tdata[0 +: 2*NODE_FW]};
    assign rd_a     = e_rdata[0 +: NODE_FW];
    assign rd_b     = e_rdata[NODE_FW +: NODE_FW];
    assign rd_w     = e_rdata[2*NODE_FW +: WB];
    assign ans_upd  = ans_reg | WB'(64'(1) << bit_reg);

    mbw_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (EAW'(cnt_reg)),
        .wdata (e_wdata),
        .raddr (EAW'(ei_reg)),
        .rdata (e_rdata)
    );

    mbw_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_parent (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Sequencer: load, then threshold passes of union-find over the edges
    always_comb begin
        state_next    = state_reg;
        ncfg_next     = ncfg_reg;
        nc_next       = nc_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        drop_next     = drop_reg;
        thr_next      = thr_reg;
        ans_next      = ans_reg;
        bit_next      = bit_reg;
        first_next    = first_reg;
        pconn_next    = pconn_reg;
        ii_next       = ii_reg;
        ei_next       = ei_reg;
        joins_next    = joins_reg;
        x_next        = x_reg;
        ra_next       = ra_reg;
        eb_next       = eb_reg;
        res_conn_next = res_conn_reg;
        res_w_next    = res_w_reg;
        m_valid_next  = m_valid_reg;
        m_conn_next   = m_conn_reg;
        m_bw_next     = m_bw_reg;
        m_drop_next   = m_drop_reg;
        p_we          = 1'b0;
        p_waddr       = NAW'(ii_reg);
        p_wdata       = NAW'(ii_reg);
        p_raddr       = x_reg;

        if (cfg_we) begin
            ncfg_next = cfg_wdata;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser) begin
                        if (e_we) begin
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        drop_next = ovf_reg || (s_tuser && !e_we);
                        if (ncfg_reg == '0) begin
                            nc_next = NCW'(1);
                        end else if (32'(ncfg_reg) > MAX_NODES) begin
                            nc_next = NCW'(MAX_NODES);
                        end else begin
                            nc_next = NCW'(ncfg_reg);
                        end
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                ii_next    = '0;
                first_next = 1'b1;
                thr_next   = '1;
                if (nc_reg == NCW'(1)) begin
                    res_conn_next = 1'b1;
                    res_w_next    = '0;
                    state_next    = S_FIN;
                end else if (cnt_reg == '0) begin
                    res_conn_next = 1'b0;
                    res_w_next    = '0;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_INIT;
                end
            end
            // Reset the parent table to identity
            S_INIT: begin
                p_we    = 1'b1;
                ii_next = ii_reg + 1'b1;
                if (ii_reg == nc_reg - 1'b1) begin
                    ii_next    = '0;
                    ei_next    = '0;
                    joins_next = '0;
                    pconn_next = 1'b0;
                    state_next = S_EREAD;
                end
            end
            S_EREAD: begin
                if (ei_reg == cnt_reg) begin
                    state_next = S_PEND;
                end else begin
                    state_next = S_ECHK;
                end
            end
            // Skip edges above the threshold or with an endpoint out of range
            S_ECHK: begin
                if (rd_w <= thr_reg && 32'(rd_a) < 32'(nc_reg)
                        && 32'(rd_b) < 32'(nc_reg)) begin
                    x_next     = NAW'(32'(rd_a));
                    eb_next    = NAW'(32'(rd_b));
                    state_next = S_FA;
                end else begin
                    ei_next    = ei_reg + 1'b1;
                    state_next = S_EREAD;
                end
            end
            S_FA: begin
                state_next = S_FAW;
            end
            S_FAW: begin
                if (p_rdata == x_reg) begin
                    ra_next    = x_reg;
                    x_next     = eb_reg;
                    state_next = S_FB;
                end else begin
                    x_next     = p_rdata;
                    state_next = S_FA;
                end
            end
            S_FB: begin
                state_next = S_FBW;
            end
            // Link the two roots when they differ
            S_FBW: begin
                if (p_rdata == x_reg) begin
                    ei_next    = ei_reg + 1'b1;
                    state_next = S_EREAD;
                    if (x_reg != ra_reg) begin
                        p_we       = 1'b1;
                        p_waddr    = ra_reg;
                        p_wdata    = x_reg;
                        joins_next = joins_reg + 1'b1;
                        if (32'(joins_reg) + 2 == 32'(nc_reg)) begin
                            pconn_next = 1'b1;
                            state_next = S_PEND;
                        end
                    end
                end else begin
                    x_next     = p_rdata;
                    state_next = S_FB;
                end
            end
            // Narrow the threshold one bit per pass, high bit first, or end the compute
            S_PEND: begin
                state_next = S_INIT;
                if (first_reg) begin
                    if (!pconn_reg) begin
                        res_conn_next = 1'b0;
                        res_w_next    = '0;
                        state_next    = S_FIN;
                    end else begin
                        first_next = 1'b0;
                        ans_next   = '0;
                        bit_next   = BIW'(WB - 1);
                        thr_next   = WB'((64'(1) << (WB - 1)) - 64'(1));
                    end
                end else begin
                    ans_next = pconn_reg ? ans_reg : ans_upd;
                    if (bit_reg == '0) begin
                        res_conn_next = 1'b1;
                        res_w_next    = pconn_reg ? ans_reg : ans_upd;
                        state_next    = S_FIN;
                    end else begin
                        bit_next = bit_reg - 1'b1;
                        thr_next = (pconn_reg ? ans_reg : ans_upd)
                                 | WB'((64'(1) << (bit_reg - 1'b1)) - 64'(1));
                    end
                end
            end
            // Hand the result to the output register, then empty the set
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_conn_next  = res_conn_reg;
                    m_bw_next    = WGT_FW'(32'(res_w_reg));
                    m_drop_next  = drop_reg;
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ncfg_reg    <= CFG_FW'(1);
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            joins_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            ncfg_reg    <= ncfg_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            joins_reg   <= joins_next;
        end
        nc_reg       <= nc_next;
        drop_reg     <= drop_next;
        thr_reg      <= thr_next;
        ans_reg      <= ans_next;
        bit_reg      <= bit_next;
        first_reg    <= first_next;
        pconn_reg    <= pconn_next;
        ii_reg       <= ii_next;
        ei_reg       <= ei_next;
        x_reg        <= x_next;
        ra_reg       <= ra_next;
        eb_reg       <= eb_next;
        res_conn_reg <= res_conn_next;
        res_w_reg    <= res_w_next;
        m_conn_reg   <= m_conn_next;
        m_bw_reg     <= m_bw_next;
        m_drop_reg   <= m_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_drop_reg, m_bw_reg, m_conn_reg};

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_EDGES)
        else $error("edge count above store size");

    a_unconn_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[20:1] == '0)
        else $error("weight nonzero on unconnected result");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready)
        else $error("input ready while computing");

    a_join_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EREAD |-> 32'(joins_reg) < 32'(nc_reg))
        else $error("join count reached node count");

endmodule

/* test/tb_mst_bottleneck_weight.sv */
`timescale 1ns / 1ps
// Testbench for mst_bottleneck_weight: loads edge sets, predicts each result
// with a sorted-edge union-find, and checks the m_ items. Depends on mbw_pkg.
module tb_mst_bottleneck_weight;
    import mbw_pkg::*;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic        has_edge;
        logic [9:0]  node_a;
        logic [9:0]  node_b;
        logic [19:0] weight;
        logic        last_edge;
    } edge_item_t;

    typedef struct packed {
        logic        connected;
        logic [19:0] bottleneck;
        logic        dropped;
    } tree_result_t;

    // Directed row: item, and whether an expected result is typed in.
    typedef struct {
        edge_item_t   item;
        logic         fixed;
        tree_result_t result;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_FW-1:0]   cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    mst_bottleneck_weight u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // Predictor state
    logic [9:0]   set_a [$];
    logic [9:0]   set_b [$];
    logic [19:0]  set_w [$];
    logic         set_overflow;
    logic [10:0]  nodes_cfg;
    tree_result_t expected_trees [$];
    stim_row_t    dir_rows [$];

    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Kruskal over the collected set: stable sort by weight, union by size.
    function automatic tree_result_t solve_tree();
        tree_result_t r;
        int nc, n, joined, i, j, ra, rb, t;
        int parent [MAX_NODES];
        int sz [MAX_NODES];
        int order [MAX_EDGES];
        logic [19:0] top;
        r = '0;
        r.dropped = set_overflow;
        nc = int'(nodes_cfg);
        if (nc == 0) nc = 1;
        if (nc > MAX_NODES) nc = MAX_NODES;
        if (nc == 1) begin
            r.connected = 1'b1;
            return r;
        end
        n = set_w.size();
        for (i = 0; i < n; i++) order[i] = i;
        // insertion sort keeps equal weights in load order
        for (i = 1; i < n; i++) begin
            t = order[i];
            j = i - 1;
            while (j >= 0 && set_w[order[j]] > set_w[t]) begin
                order[j + 1] = order[j];
                j--;
            end
            order[j + 1] = t;
        end
        for (i = 0; i < nc; i++) begin
            parent[i] = i;
            sz[i] = 1;
        end
        joined = 0;
        top = '0;
        for (i = 0; i < n; i++) begin
            t = order[i];
            if (int'(set_a[t]) >= nc || int'(set_b[t]) >= nc) continue;
            ra = int'(set_a[t]);
            while (parent[ra] != ra) ra = parent[ra];
            rb = int'(set_b[t]);
            while (parent[rb] != rb) rb = parent[rb];
            if (ra == rb) continue;
            if (sz[ra] >= sz[rb]) begin
                parent[rb] = ra;
                sz[ra] += sz[rb];
            end else begin
                parent[ra] = rb;
                sz[rb] += sz[ra];
            end
            if (set_w[t] > top) top = set_w[t];
            joined++;
            if (joined == nc - 1) begin
                r.connected = 1'b1;
                r.bottleneck = top;
                return r;
            end
        end
        return r;
    endfunction

    // Advance the predictor by one accepted item.
    function automatic void absorb_edge(input edge_item_t it, input logic fixed,
                                        input tree_result_t want);
        tree_result_t r;
        if (it.has_edge) begin
            if (set_w.size() < MAX_EDGES) begin
                set_a.insert(set_a.size(), it.node_a);
                set_b.insert(set_b.size(), it.node_b);
                set_w.insert(set_w.size(), it.weight);
            end else begin
                set_overflow = 1'b1;
            end
        end
        if (it.last_edge) begin
            r = solve_tree();
            if (fixed && r != want)
                $display("note: typed result differs from predictor at %0t", $realtime);
            expected_trees.insert(expected_trees.size(), fixed ? want : r);
            set_a.delete();
            set_b.delete();
            set_w.delete();
            set_overflow = 1'b0;
        end
    endfunction

    task automatic send_edge(input edge_item_t it, input logic fixed,
                             input tree_result_t want);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.weight, it.node_b, it.node_a};
        s_tuser  <= it.has_edge;
        s_tlast  <= it.last_edge;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_edge(it, fixed, want);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_trees.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_nodes(input logic [10:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        nodes_cfg = v;
    endtask

    function automatic edge_item_t mk(input logic h, input int a, input int b,
                                      input int w, input logic l);
        edge_item_t it;
        it.has_edge = h;
        it.node_a = 10'(a);
        it.node_b = 10'(b);
        it.weight = 20'(w);
        it.last_edge = l;
        return it;
    endfunction

    function automatic void add_row(input edge_item_t it, input logic fixed,
                                    input logic c, input int w, input logic d);
        stim_row_t row;
        row.item = it;
        row.fixed = fixed;
        row.result.connected = c;
        row.result.bottleneck = 20'(w);
        row.result.dropped = d;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Check each result against the oldest expectation.
    always @(posedge aclk) begin
        tree_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_trees.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                want = expected_trees.pop_front();
                if (m_tdata[0] !== want.connected)
                    report_mismatch("connected", m_tdata[0], want.connected);
                if (m_tdata[20:1] !== want.bottleneck)
                    report_mismatch("bottleneck_weight", m_tdata[20:1], want.bottleneck);
                if (m_tdata[21] !== want.dropped)
                    report_mismatch("edges_dropped", m_tdata[21], want.dropped);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (600) @(negedge aclk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else if (!stim_done || expected_trees.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        edge_item_t it;
        int k, nsets, len, nc, pick;
        set_overflow = 1'b0;
        nodes_cfg = 11'd1;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: single node after reset, empty set, extremes, loops.
        add_row(mk(1, 5, 9, 77, 1), 1, 1, 0, 0);
        add_row(mk(0, 0, 0, 0, 1), 1, 1, 0, 0);
        foreach (dir_rows[i]) send_edge(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
        settle();
        dir_rows.delete();
        set_nodes(11'd2);
        add_row(mk(0, 0, 0, 0, 1), 1, 0, 0, 0);
        add_row(mk(0, 1023, 1023, 0, 0), 0, 0, 0, 0);
        add_row(mk(1, 0, 0, 1048575, 0), 0, 0, 0, 0);
        add_row(mk(1, 0, 1, 1048575, 1), 1, 1, 1048575, 0);
        add_row(mk(1, 1, 0, 0, 1), 1, 1, 0, 0);
        add_row(mk(1, 1023, 0, 5, 0), 0, 0, 0, 0);
        add_row(mk(1, 0, 1023, 6, 1), 1, 0, 0, 0);
        add_row(mk(1, 0, 1, 9, 0), 0, 0, 0, 0);
        add_row(mk(1, 1, 0, 3, 0), 0, 0, 0, 0);
        add_row(mk(1, 0, 1, 12, 1), 0, 0, 0, 0);
        foreach (dir_rows[i]) send_edge(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
        settle();
        dir_rows.delete();
        set_nodes(11'd0);
        add_row(mk(0, 0, 0, 0, 1), 1, 1, 0, 0);
        foreach (dir_rows[i]) send_edge(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
        settle();
        dir_rows.delete();
        set_nodes(11'd2047);
        add_row(mk(1, 1023, 1022, 1, 0), 0, 0, 0, 0);
        add_row(mk(0, 0, 0, 0, 1), 1, 0, 0, 0);
        foreach (dir_rows[i]) send_edge(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
        settle();
        dir_rows.delete();

        // Pressure: the receiver holds off so the block stalls on the next sets.
        set_nodes(11'd2);
        hold_off = 1'b1;
        for (k = 0; k < 6; k++)
            send_edge(mk(1, 0, 1, int'($urandom_range(0, 1048575)), 1'b1), 0, '0);
        settle();

        // Random sets: mostly small graphs with random content.
        for (nsets = 0; nsets < 8; nsets++) begin
            case (nsets)
                0: nc = 1;
                1: nc = 1024;
                default: nc = $urandom_range(2, 12);
            endcase
            set_nodes(11'(nc));
            for (k = 0; k < 22; k++) begin
                len = $urandom_range(0, 12);
                for (int e = 0; e <= len; e++) begin
                    pick = $urandom_range(0, 9);
                    it.has_edge = pick != 0;
                    it.node_a = pick == 1 ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, nc));
                    it.node_b = pick == 2 ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, nc));
                    it.weight = $urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 1048575))
                                                         : 20'($urandom_range(0, 15));
                    it.last_edge = e == len;
                    send_edge(it, 0, '0);
                end
            end
            settle();
        end
        stim_done = 1'b1;
        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
